// ===== design/uvss_pkg.sv =====
// Shared types and constants for the unique value set store.
// Used by every module of the block; depends on nothing.

package uvss_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int FILL_W   = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_LIST   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_PRESENT = 3'd1,
        ST_ABSENT  = 3'd2,
        ST_FULL    = 3'd3,
        ST_ENTRY   = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic wrap;
    } cell_ctrl_t;

endpackage

// ===== design/uvss_cell.sv =====
// One storage cell of the set: holds one value and compares it to the request.
// Depends on uvss_pkg for the value width and the cell control struct.

module uvss_cell (
    input  logic                          aclk,
    input  uvss_pkg::cell_ctrl_t          ctrl,
    input  logic [uvss_pkg::VALUE_W-1:0]  req_value,
    input  logic [uvss_pkg::VALUE_W-1:0]  right_value,
    input  logic [uvss_pkg::VALUE_W-1:0]  head_value,
    output logic [uvss_pkg::VALUE_W-1:0]  value,
    output logic                          match
);
    import uvss_pkg::*;

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctrl.load) begin
            value_next = req_value;
        end else if (ctrl.shift) begin
            value_next = ctrl.wrap ? head_value : right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = (value_reg == req_value);

endmodule

// ===== design/unique_value_set_store_top.sv =====
// Ordered set of distinct 32-bit values held in a row of CAPACITY cells. Add, remove
// and find first accept the request, then move to a compare state in which every cell
// compares its value in parallel and the chain loads, closes the gap or holds. List
// rotates the chain one place a cycle through cell 0 while the result output is free
// and gives one result per entry, so the store is back in order when it ends. A request
// waits in its compare cycle while the previous result has not been taken.

module unique_value_set_store_top #(
    parameter int CAPACITY = uvss_pkg::CAPACITY_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [uvss_pkg::OPCODE_W-1:0]         s_opcode,
    input  logic signed [uvss_pkg::VALUE_W-1:0]   s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [uvss_pkg::STATUS_W-1:0]         m_status,
    output logic [uvss_pkg::POS_W-1:0]            m_position,
    output logic signed [uvss_pkg::VALUE_W-1:0]   m_entry_value,
    output logic [uvss_pkg::FILL_W-1:0]           m_fill_count,
    output logic                                  m_last
);
    import uvss_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LIST = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    opcode_t             op_reg;
    logic [VALUE_W-1:0]  req_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    list_cnt_reg, list_cnt_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [POS_W-1:0]    m_position_reg;
    logic [VALUE_W-1:0]  m_entry_value_reg;
    logic [FILL_W-1:0]   m_fill_count_reg;
    logic                m_last_reg;

    logic                out_load;
    status_t             out_status;
    logic [POS_W-1:0]    out_position;
    logic [VALUE_W-1:0]  out_value;
    logic                out_last;
    logic                out_free;

    logic [VALUE_W-1:0]  cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    cell_ctrl_t          cell_ctrl  [CAPACITY];

    logic [CAPACITY-1:0] hit;
    logic                hit_any;
    logic [IDX_W-1:0]    hit_idx;
    logic                emit_now;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] right;
        if (g == CAPACITY - 1) begin : g_tail
            assign right = '0;
        end else begin : g_body
            assign right = cell_value[g+1];
        end
        uvss_cell u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl[g]),
            .req_value   (req_reg),
            .right_value (right),
            .head_value  (cell_value[0]),
            .value       (cell_value[g]),
            .match       (cell_match[g])
        );
    end

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit[i] = cell_match[i] && (CNT_W'(i) < count_reg);
            if (hit[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
        hit_any = |hit;
    end

    assign out_free = !m_valid_reg || m_ready;
    assign emit_now = (32'(list_cnt_reg) < 32'(MAX_RESULTS));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        list_cnt_next = list_cnt_reg;
        s_ready       = 1'b0;
        out_load      = 1'b0;
        out_status    = ST_DONE;
        out_position  = '0;
        out_value     = req_reg;
        out_last      = 1'b1;
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctrl[i] = '0;
        end

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_ADD: begin
                            if (hit_any) begin
                                out_status   = ST_PRESENT;
                                out_position = POS_W'(hit_idx);
                            end else if (count_reg == CNT_W'(CAPACITY)) begin
                                out_status = ST_FULL;
                            end else begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    cell_ctrl[i].load = (CNT_W'(i) == count_reg);
                                end
                                count_next   = count_reg + CNT_W'(1);
                                out_position = POS_W'(count_reg);
                            end
                        end
                        OP_REMOVE: begin
                            if (hit_any) begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    cell_ctrl[i].shift = (IDX_W'(i) >= hit_idx) &&
                                        (CNT_W'(i) + CNT_W'(1) < count_reg);
                                end
                                count_next   = count_reg - CNT_W'(1);
                                out_position = POS_W'(hit_idx);
                            end else begin
                                out_status = ST_ABSENT;
                            end
                        end
                        OP_FIND: begin
                            if (hit_any) begin
                                out_position = POS_W'(hit_idx);
                            end else begin
                                out_status = ST_ABSENT;
                            end
                        end
                        OP_LIST: begin
                            if (count_reg == '0) begin
                                out_status = ST_EMPTY;
                                out_value  = '0;
                            end else begin
                                out_load      = 1'b0;
                                list_cnt_next = '0;
                                state_next    = S_LIST;
                            end
                        end
                        default: begin
                            out_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (!emit_now || out_free) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        cell_ctrl[i].shift = (CNT_W'(i) < count_reg);
                        cell_ctrl[i].wrap  = (CNT_W'(i) + CNT_W'(1) == count_reg);
                    end
                    out_load      = emit_now;
                    out_status    = ST_ENTRY;
                    out_position  = POS_W'(list_cnt_reg);
                    out_value     = cell_value[0];
                    out_last      = (CNT_W'(list_cnt_reg) + CNT_W'(1) == count_reg) ||
                                    (32'(list_cnt_reg) + 32'd1 == 32'(MAX_RESULTS));
                    list_cnt_next = list_cnt_reg + IDX_W'(1);
                    if (CNT_W'(list_cnt_reg) + CNT_W'(1) == count_reg) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            list_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_cnt_reg <= list_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= opcode_t'(s_opcode);
            req_reg <= s_value;
        end
        if (out_load) begin
            m_status_reg      <= out_status;
            m_position_reg    <= out_position;
            m_entry_value_reg <= out_value;
            m_fill_count_reg  <= FILL_W'(count_next);
            m_last_reg        <= out_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_position    = m_position_reg;
    assign m_entry_value = m_entry_value_reg;
    assign m_fill_count  = m_fill_count_reg;
    assign m_last        = m_last_reg;

endmodule

// ===== design/uvss_checker.sv =====
// Port-level checks for the unique value set store, bound to the top level.
// Depends on uvss_pkg for field widths and status codes.

module uvss_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic [uvss_pkg::OPCODE_W-1:0]         s_opcode,
    input logic signed [uvss_pkg::VALUE_W-1:0]   s_value,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [uvss_pkg::STATUS_W-1:0]         m_status,
    input logic [uvss_pkg::POS_W-1:0]            m_position,
    input logic signed [uvss_pkg::VALUE_W-1:0]   m_entry_value,
    input logic [uvss_pkg::FILL_W-1:0]           m_fill_count,
    input logic                                  m_last
);
    import uvss_pkg::*;

    logic [STATUS_W-1:0] st_absent, st_full, st_empty;
    assign st_absent = ST_ABSENT;
    assign st_full   = ST_FULL;
    assign st_empty  = ST_EMPTY;

    a_hold_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_opcode) && $stable(s_value))
        else $error("request changed while waiting");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_position) &&
            $stable(m_entry_value) && $stable(m_fill_count) && $stable(m_last))
        else $error("result changed while stalled");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in flight");

    a_zero_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == st_absent || m_status == st_full ||
            m_status == st_empty) |-> m_position == '0)
        else $error("nonzero position on a miss result");

    a_empty_list: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == st_empty |-> m_last && m_fill_count == '0 &&
            m_entry_value == '0)
        else $error("empty list result malformed");

endmodule

bind unique_value_set_store_top uvss_checker u_uvss_checker (.*);
